// ----- rtl/bia_pkg.sv -----
// Shared constants and types for the bounded integer array engine.
// No dependencies; imported by bia_ram users and the top level.
package bia_pkg;

  // Capacity of the element memory
  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Fixed field widths of the command and result beats
  localparam int OP_W   = 4;
  localparam int IDX_W  = 6;
  localparam int DATA_W = 32;
  localparam int SIZE_W = 7;

  // Command opcodes; codes 12 to 15 are rejected
  typedef enum logic [OP_W-1:0] {
    OP_PUSH     = 4'd0,
    OP_POP      = 4'd1,
    OP_INSERT   = 4'd2,
    OP_REMOVE   = 4'd3,
    OP_CLEAR    = 4'd4,
    OP_GET      = 4'd5,
    OP_CONTAINS = 4'd6,
    OP_COUNT    = 4'd7,
    OP_SUM      = 4'd8,
    OP_MAX      = 4'd9,
    OP_MIN      = 4'd10,
    OP_STATUS   = 4'd11
  } op_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_GET,
    S_SCAN,
    S_SHIFT_UP,
    S_PUT,
    S_SHIFT_DN,
    S_DONE
  } state_t;

endpackage

// ----- rtl/bia_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies. Contents are undefined until written.
module bia_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/bounded_int_array_engine_top.sv -----
// Bounded integer array engine: ordered array of signed 32-bit entries in one RAM.
// Push, pop, clear, status and rejects end in S_START; get reads one entry;
// contains, count, sum, max, min walk all entries; insert shifts entries up,
// remove shifts later entries down. One command at a time; next beat taken the
// cycle after the result is registered. The single RAM read port sets the walk rate.
// Reset clears the size and handshake state; the RAM needs no clearing pass.
module bounded_int_array_engine_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bia_pkg::OP_W-1:0]      opcode,
  input  logic [bia_pkg::IDX_W-1:0]     index,
  input  logic signed [bia_pkg::DATA_W-1:0] value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          ok,
  output logic signed [bia_pkg::DATA_W-1:0] result_value,
  output logic [bia_pkg::SIZE_W-1:0]    current_size,
  output logic                          is_full,
  output logic                          is_empty
);
  import bia_pkg::*;

  state_t              state, state_next;
  logic [OP_W-1:0]     op_q;
  logic [IDX_W-1:0]    idx_q;
  logic [DATA_W-1:0]   val_q;
  logic [ADDR_W-1:0]   ptr, ptr_next;
  logic [CNT_W-1:0]    fill, fill_next;
  logic [DATA_W-1:0]   acc, acc_next;
  logic                ok_r, ok_r_next;

  // RAM port signals
  logic                mem_we, mem_re;
  logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
  logic [DATA_W-1:0]   mem_wdata, mem_rdata;

  // Derived compares
  logic [CNT_W-1:0]        fill_m1;
  logic [IDX_W+CNT_W-1:0]  idx_wide, fill_wide, fill_m1_wide;
  logic [ADDR_W-1:0]       idx_addr;
  logic                    idx_ok, idx_last, arr_full, arr_empty, ptr_last, first, match;
  logic [SIZE_W+CNT_W-1:0] size_wide;
  logic                    load_out;

  bia_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign fill_m1      = fill - CNT_W'(1);
  assign idx_wide     = {{CNT_W{1'b0}}, idx_q};
  assign fill_wide    = {{IDX_W{1'b0}}, fill};
  assign fill_m1_wide = {{IDX_W{1'b0}}, fill_m1};
  assign idx_addr     = idx_wide[ADDR_W-1:0];
  assign idx_ok       = idx_wide < fill_wide;
  assign idx_last     = idx_wide == fill_m1_wide;
  assign arr_full     = fill == CNT_W'(DEPTH);
  assign arr_empty    = fill == '0;
  assign ptr_last     = CNT_W'(ptr) == fill_m1;
  assign first        = ptr == '0;
  assign match        = mem_rdata == val_q;
  assign size_wide    = {{SIZE_W{1'b0}}, fill};
  assign in_ready     = state == S_IDLE;
  assign load_out     = (state == S_DONE) && (!out_valid || out_ready);

  // Next state and RAM control
  always_comb begin
    state_next = state;
    ptr_next   = ptr;
    fill_next  = fill;
    acc_next   = acc;
    ok_r_next  = ok_r;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = '0;
    mem_raddr  = '0;
    mem_wdata  = val_q;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_START;
        end
      end
      S_START: begin
        acc_next   = '0;
        ok_r_next  = 1'b0;
        state_next = S_DONE;
        case (op_q) inside
          OP_PUSH: begin
            if (!arr_full) begin
              mem_we    = 1'b1;
              mem_waddr = ADDR_W'(fill);
              fill_next = fill + CNT_W'(1);
              ok_r_next = 1'b1;
            end
          end
          OP_POP: begin
            if (!arr_empty) begin
              fill_next = fill_m1;
              ok_r_next = 1'b1;
            end
          end
          OP_INSERT: begin
            if (idx_ok && !arr_full) begin
              ok_r_next  = 1'b1;
              mem_re     = 1'b1;
              mem_raddr  = ADDR_W'(fill_m1);
              ptr_next   = ADDR_W'(fill_m1);
              state_next = S_SHIFT_UP;
            end
          end
          OP_REMOVE: begin
            if (idx_ok) begin
              ok_r_next = 1'b1;
              if (idx_last) begin
                fill_next = fill_m1;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = idx_addr + ADDR_W'(1);
                ptr_next   = idx_addr + ADDR_W'(1);
                state_next = S_SHIFT_DN;
              end
            end
          end
          OP_CLEAR: begin
            fill_next = '0;
            ok_r_next = 1'b1;
          end
          OP_GET: begin
            if (idx_ok) begin
              ok_r_next  = 1'b1;
              mem_re     = 1'b1;
              mem_raddr  = idx_addr;
              state_next = S_GET;
            end
          end
          OP_CONTAINS, OP_COUNT, OP_SUM: begin
            ok_r_next = 1'b1;
            if (!arr_empty) begin
              mem_re     = 1'b1;
              ptr_next   = '0;
              state_next = S_SCAN;
            end
          end
          OP_MAX, OP_MIN: begin
            if (!arr_empty) begin
              ok_r_next  = 1'b1;
              mem_re     = 1'b1;
              ptr_next   = '0;
              state_next = S_SCAN;
            end
          end
          OP_STATUS: begin
            ok_r_next = 1'b1;
          end
          default: begin
            ok_r_next = 1'b0;
          end
        endcase
      end
      S_GET: begin
        acc_next   = mem_rdata;
        state_next = S_DONE;
      end
      S_SCAN: begin
        // fold one entry into the accumulator
        case (op_q) inside
          OP_CONTAINS: acc_next = match ? DATA_W'(1) : acc;
          OP_COUNT:    acc_next = acc + DATA_W'(match);
          OP_SUM:      acc_next = acc + mem_rdata;
          OP_MAX: begin
            if (first || ($signed(mem_rdata) > $signed(acc))) acc_next = mem_rdata;
          end
          OP_MIN: begin
            if (first || ($signed(mem_rdata) < $signed(acc))) acc_next = mem_rdata;
          end
          default: acc_next = acc;
        endcase
        if (ptr_last) begin
          state_next = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr + ADDR_W'(1);
          ptr_next  = ptr + ADDR_W'(1);
        end
      end
      S_SHIFT_UP: begin
        // move entry ptr to ptr+1, walking down toward the insert point
        mem_we    = 1'b1;
        mem_waddr = ptr + ADDR_W'(1);
        mem_wdata = mem_rdata;
        if (ptr == idx_addr) begin
          state_next = S_PUT;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr - ADDR_W'(1);
          ptr_next  = ptr - ADDR_W'(1);
        end
      end
      S_PUT: begin
        mem_we     = 1'b1;
        mem_waddr  = idx_addr;
        fill_next  = fill + CNT_W'(1);
        state_next = S_DONE;
      end
      S_SHIFT_DN: begin
        // move entry ptr to ptr-1, walking up toward the end
        mem_we    = 1'b1;
        mem_waddr = ptr - ADDR_W'(1);
        mem_wdata = mem_rdata;
        if (ptr_last) begin
          fill_next  = fill_m1;
          state_next = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr + ADDR_W'(1);
          ptr_next  = ptr + ADDR_W'(1);
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Command, walk and result registers
  always_ff @(posedge clk) begin
    ptr  <= ptr_next;
    acc  <= acc_next;
    ok_r <= ok_r_next;
    if (in_valid && in_ready) begin
      op_q  <= opcode;
      idx_q <= index;
      val_q <= value;
    end
    if (load_out) begin
      ok           <= ok_r;
      result_value <= acc;
      current_size <= size_wide[SIZE_W-1:0];
      is_full      <= arr_full;
      is_empty     <= arr_empty;
    end
  end

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= CNT_W'(DEPTH))
    else $error("fill count above capacity");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !ok) |-> (result_value == '0))
    else $error("rejected command with nonzero result");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_full && is_empty))
    else $error("full and empty both set");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("read and write to the same entry in one cycle");

endmodule
